// ===== sv/btm_pkg.sv =====
// shared constants and widths for the bracket tape machine
`timescale 1ns / 1ps
package btm_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 4096;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
  localparam int CLR_LEN    = (PROG_DEPTH > TAPE_DEPTH) ? PROG_DEPTH : TAPE_DEPTH;
  localparam int CLR_AW     = $clog2(CLR_LEN);
  localparam int TAPE_MID   = TAPE_DEPTH / 2;

  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int PC_W   = 12;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

endpackage

// ===== sv/btm_if.sv =====
// item and result channel interfaces
`timescale 1ns / 1ps
interface btm_in_if import btm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] value;

  modport source (output valid, output opcode, output address, output value, input ready);
  modport sink   (input valid, input opcode, input address, input value, output ready);
endinterface

interface btm_out_if import btm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              has_output;
  logic [BYTE_W-1:0] output_byte;
  logic [PC_W-1:0]   program_counter;

  modport source (output valid, output has_output, output output_byte,
                  output program_counter, input ready);
  modport sink   (input valid, input has_output, input output_byte,
                  input program_counter, output ready);
endinterface

// ===== sv/btm_ram.sv =====
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps
module btm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/bracket_tape_machine_step_core.sv =====
// top level: eight-instruction tape machine with program and tape rams
//
// usage: items arrive on the item channel (valid/ready), results leave on
// the result channel (valid/ready); every item gives exactly one result.
// a load item writes one program byte and its result is registered at the
// transfer, so it appears on the next cycle.
// a step item first reads the program byte and the tape cell from their
// rams, then executes and writes the cell back. a taken bracket then
// scans the program ram one byte a cycle until the match or the end.
// after reset both rams are swept to zero, one entry a cycle, and no
// item is accepted during the sweep.
// a new item is accepted while the last result is being transferred; if
// the receiver stalls, the result is held and the item channel stays
// not ready until the result register frees up.
`timescale 1ns / 1ps
module bracket_tape_machine_step_core import btm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  btm_in_if.sink       item,
  btm_out_if.source    result
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [CLR_AW-1:0]  clr_cnt, clr_cnt_next;
  logic [PROG_AW:0]   ip, ip_next;
  logic [TAPE_AW:0]   tp, tp_next;
  logic [BYTE_W-1:0]  val_r, val_r_next;
  logic [PROG_AW:0]   pos, pos_next;
  logic [PROG_AW:0]   nest, nest_next;
  logic               fwd, fwd_next;
  logic               out_valid, out_valid_next;
  logic               out_has, out_has_next;
  logic [BYTE_W-1:0]  out_byte, out_byte_next;
  logic [PC_W-1:0]    out_pc, out_pc_next;

  logic               prog_we;
  logic [PROG_AW-1:0] prog_addr;
  logic [BYTE_W-1:0]  prog_wdata, prog_rdata;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_addr;
  logic [BYTE_W-1:0]  tape_wdata, tape_rdata;

  logic               take;
  logic [PROG_AW:0]   ip_chk, scan_pos;
  logic [TAPE_AW:0]   tp_chk;
  logic [BYTE_W-1:0]  self_ch, partner_ch;

  function automatic logic out_of_range(input logic [PROG_AW:0] p);
    return (p == '0) || (p >= (PROG_AW+1)'(PROG_DEPTH));
  endfunction

  btm_ram #(.WIDTH(BYTE_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .addr  (prog_addr),
    .wdata (prog_wdata),
    .rdata (prog_rdata)
  );

  btm_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .addr  (tape_addr),
    .wdata (tape_wdata),
    .rdata (tape_rdata)
  );

  assign item.ready             = (state == S_IDLE) && (!out_valid || result.ready);
  assign take                   = item.valid && item.ready;
  assign result.valid           = out_valid;
  assign result.has_output      = out_has;
  assign result.output_byte     = out_byte;
  assign result.program_counter = out_pc;

  // pointer check done before every step
  assign ip_chk = (ip == '0 || ip >= (PROG_AW+1)'(PROG_DEPTH)) ? '0 : ip;
  assign tp_chk = (tp == '0 || tp >= (TAPE_AW+1)'(TAPE_DEPTH)) ?
                  (TAPE_AW+1)'(TAPE_MID) : tp;

  assign self_ch    = fwd ? CH_OPEN : CH_CLOSE;
  assign partner_ch = fwd ? CH_CLOSE : CH_OPEN;

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    ip_next        = ip;
    tp_next        = tp;
    val_r_next     = val_r;
    pos_next       = pos;
    nest_next      = nest;
    fwd_next       = fwd;
    out_valid_next = out_valid && !result.ready;
    out_has_next   = out_has;
    out_byte_next  = out_byte;
    out_pc_next    = out_pc;
    prog_we        = 1'b0;
    prog_addr      = ip_chk[PROG_AW-1:0];
    prog_wdata     = item.value;
    tape_we        = 1'b0;
    tape_addr      = tp[TAPE_AW-1:0];
    tape_wdata     = tape_rdata;
    scan_pos       = ip;

    case (state)
      S_CLEAR: begin
        prog_we    = (32'(clr_cnt) < PROG_DEPTH);
        prog_addr  = PROG_AW'(clr_cnt);
        prog_wdata = '0;
        tape_we    = (32'(clr_cnt) < TAPE_DEPTH);
        tape_addr  = TAPE_AW'(clr_cnt);
        tape_wdata = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (32'(clr_cnt) == CLR_LEN - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        tape_addr = tp_chk[TAPE_AW-1:0];
        if (take) begin
          if (item.opcode == OP_LOAD) begin
            prog_addr      = PROG_AW'(item.address);
            prog_we        = (32'(item.address) < PROG_DEPTH);
            out_valid_next = 1'b1;
            out_has_next   = 1'b0;
            out_byte_next  = '0;
            out_pc_next    = PC_W'(ip);
          end else begin
            ip_next    = ip_chk;
            tp_next    = tp_chk;
            val_r_next = item.value;
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        out_has_next  = 1'b0;
        out_byte_next = '0;
        out_pc_next   = PC_W'(ip + 1'b1);
        state_next    = S_IDLE;
        case (prog_rdata)
          CH_RIGHT: tp_next = tp + 1'b1;
          CH_LEFT:  tp_next = tp - 1'b1;
          CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 1'b1;
          end
          CH_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 1'b1;
          end
          CH_OUT: begin
            out_has_next  = 1'b1;
            out_byte_next = tape_rdata;
          end
          CH_IN: begin
            tape_we    = 1'b1;
            tape_wdata = val_r;
          end
          CH_OPEN, CH_CLOSE: begin
            // taken when '[' sees zero or ']' sees nonzero
            if ((prog_rdata == CH_OPEN) == (tape_rdata == '0)) begin
              scan_pos = (prog_rdata == CH_OPEN) ? ip + 1'b1 : ip - 1'b1;
              if (!(ip == '0 && prog_rdata == CH_CLOSE) && !out_of_range(scan_pos)) begin
                prog_addr  = scan_pos[PROG_AW-1:0];
                pos_next   = scan_pos;
                nest_next  = '0;
                fwd_next   = (prog_rdata == CH_OPEN);
                state_next = S_SCAN;
              end
            end
          end
          default: ;
        endcase
        if (state_next == S_IDLE) begin
          ip_next        = ip + 1'b1;
          out_valid_next = 1'b1;
        end
      end
      S_SCAN: begin
        if (prog_rdata == partner_ch && nest == '0) begin
          ip_next        = pos + 1'b1;
          out_valid_next = 1'b1;
          out_has_next   = 1'b0;
          out_byte_next  = '0;
          out_pc_next    = PC_W'(pos + 1'b1);
          state_next     = S_IDLE;
        end else begin
          if (prog_rdata == self_ch) begin
            nest_next = nest + 1'b1;
          end else if (prog_rdata == partner_ch) begin
            nest_next = nest - 1'b1;
          end
          scan_pos = fwd ? pos + 1'b1 : pos - 1'b1;
          if (out_of_range(scan_pos)) begin
            // unmatched: step past the bracket as usual
            ip_next        = ip + 1'b1;
            out_valid_next = 1'b1;
            out_has_next   = 1'b0;
            out_byte_next  = '0;
            out_pc_next    = PC_W'(ip + 1'b1);
            state_next     = S_IDLE;
          end else begin
            prog_addr = scan_pos[PROG_AW-1:0];
            pos_next  = scan_pos;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ip        <= '0;
      tp        <= (TAPE_AW+1)'(TAPE_MID);
      out_valid <= 1'b0;
      nest      <= '0;
      fwd       <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      ip        <= ip_next;
      tp        <= tp_next;
      out_valid <= out_valid_next;
      nest      <= nest_next;
      fwd       <= fwd_next;
    end
    val_r    <= val_r_next;
    pos      <= pos_next;
    out_has  <= out_has_next;
    out_byte <= out_byte_next;
    out_pc   <= out_pc_next;
  end

endmodule

// ===== dv/tb_bracket_tape_machine_step_core.sv =====
// self-checking testbench for the bracket tape machine step core
`timescale 1ns / 1ps
module tb_bracket_tape_machine_step_core;
  import btm_pkg::*;

  localparam int RANDOM_TARGET = 850;
  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic              has_output;
    logic [BYTE_W-1:0] output_byte;
    logic [PC_W-1:0]   program_counter;
  } result_t;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] val;
    bit                typed;
    result_t           want;
  } stim_row_t;

  localparam result_t NONE_AT_ONE = {1'b0, 8'h00, 12'd1};

  logic clk = 1'b0;
  logic rst = 1'b1;

  btm_in_if  item_ch ();
  btm_out_if res_ch ();

  bracket_tape_machine_step_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the machine
  logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
  logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];
  int ip;
  int tp;
  int n_loads, n_steps, n_emits, tape_resets, store_ends;

  result_t   due_results [$];
  stim_row_t stim_table [$];
  logic [BYTE_W-1:0] plain_ops [6];
  int mismatches;
  int sent;
  int idle_cycles;
  bit quiet;

  function automatic int gap_pct();
    return quiet ? 0 : 36;
  endfunction

  // scan away from a bracket for its partner; the start position when unmatched
  function automatic int partner_of(int from);
    logic [BYTE_W-1:0] own_ch;
    logic [BYTE_W-1:0] other_ch;
    int dir;
    int pos;
    int depth;
    own_ch   = prog_mem[from];
    other_ch = (own_ch == CH_OPEN) ? CH_CLOSE : CH_OPEN;
    dir      = (own_ch == CH_OPEN) ? 1 : -1;
    depth    = 0;
    pos      = from + dir;
    while (pos > 0 && pos < PROG_DEPTH) begin
      if (prog_mem[pos] == own_ch) begin
        depth++;
      end else if (prog_mem[pos] == other_ch) begin
        if (depth == 0) return pos;
        depth--;
      end
      pos += dir;
    end
    return from;
  endfunction

  function automatic result_t execute_item(logic op, logic [ADDR_W-1:0] addr,
                                           logic [BYTE_W-1:0] val);
    result_t r;
    logic [BYTE_W-1:0] cur_val;
    r = '0;
    if (op == OP_LOAD) begin
      prog_mem[addr] = val;
      n_loads++;
    end else begin
      n_steps++;
      if (ip == 0 || ip >= PROG_DEPTH) ip = 0;
      if (tp == 0 || tp >= TAPE_DEPTH) begin
        tp = TAPE_MID;
        tape_resets++;
      end
      cur_val = tape_mem[tp];
      case (prog_mem[ip])
        CH_RIGHT: tp++;
        CH_LEFT:  tp--;
        CH_INC:   tape_mem[tp] = cur_val + 8'd1;
        CH_DEC:   tape_mem[tp] = cur_val - 8'd1;
        CH_OUT: begin
          r.has_output  = 1'b1;
          r.output_byte = cur_val;
          n_emits++;
        end
        CH_IN:    tape_mem[tp] = val;
        CH_OPEN:  if (cur_val == '0) ip = partner_of(ip);
        CH_CLOSE: if (cur_val != '0) ip = partner_of(ip);
        default: ;
      endcase
      ip++;
      if (ip == PROG_DEPTH) store_ends++;
    end
    r.program_counter = PC_W'(ip);
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic send_item(logic op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] val,
                           bit typed, result_t want);
    result_t predicted;
    quiet = (sent >= 300 && sent < 450);
    if ($urandom_range(99) < gap_pct()) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct());
    end
    item_ch.valid   <= 1'b1;
    item_ch.opcode  <= op;
    item_ch.address <= addr;
    item_ch.value   <= val;
    do @(posedge clk); while (!item_ch.ready);
    predicted = execute_item(op, addr, val);
    due_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic add_row(logic op, int addr, logic [BYTE_W-1:0] val, bit typed, result_t want);
    stim_row_t row;
    row.op    = op;
    row.addr  = ADDR_W'(addr);
    row.val   = val;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // a short program at the instruction pointer, mostly with balanced brackets
  task automatic run_segment();
    logic [BYTE_W-1:0] code [$];
    int start;
    int len;
    int depth;
    int pick;
    int n;
    bit broken;
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(OP_LOAD, ADDR_W'($urandom_range(PROG_DEPTH - 1)),
                           BYTE_W'($urandom_range(255)), 1'b0, '0);
    end
    len    = $urandom_range(3, 16);
    broken = ($urandom_range(9) == 0);
    depth  = 0;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(11);
      if (pick < 6) begin
        code.push_back(plain_ops[pick]);
      end else if (pick < 8) begin
        code.push_back(CH_OPEN);
        depth++;
      end else if (pick < 10) begin
        if (depth > 0) begin
          code.push_back(CH_CLOSE);
          depth--;
        end else begin
          code.push_back(CH_IN);
        end
      end else if (pick == 10) begin
        code.push_back(BYTE_W'($urandom_range(255)));
      end else begin
        code.push_back(CH_OUT);
      end
    end
    if (!broken) begin
      while (depth > 0) begin
        code.push_back(CH_CLOSE);
        depth--;
      end
    end else if ($urandom_range(1) == 1) begin
      code.push_back(CH_CLOSE);
    end
    start = (ip == 0 || ip >= PROG_DEPTH) ? 0 : ip;
    foreach (code[i]) begin
      if (start + i < PROG_DEPTH) send_item(OP_LOAD, ADDR_W'(start + i), code[i], 1'b0, '0);
    end
    n = $urandom_range(code.size(), 3 * code.size());
    repeat (n) send_item(OP_STEP, ADDR_W'($urandom_range(PROG_DEPTH - 1)),
                         BYTE_W'($urandom_range(255)), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= gap_pct());
  end

  always @(negedge clk) begin : result_check
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result transfer with nothing outstanding");
      end else begin
        want = due_results.pop_front();
        if (res_ch.has_output !== want.has_output)
          flag_mismatch($sformatf("has_output %b, expected %b",
                                  res_ch.has_output, want.has_output));
        if (res_ch.output_byte !== want.output_byte)
          flag_mismatch($sformatf("output_byte %h, expected %h",
                                  res_ch.output_byte, want.output_byte));
        if (res_ch.program_counter !== want.program_counter)
          flag_mismatch($sformatf("program_counter %0d, expected %0d",
                                  res_ch.program_counter, want.program_counter));
      end
    end
  end

  // covers the clearing sweep after reset and a full-length bracket scan
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.opcode  = OP_LOAD;
    item_ch.address = '0;
    item_ch.value   = '0;
    res_ch.ready    = 1'b0;
    plain_ops = '{CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN};
    for (int i = 0; i < PROG_DEPTH; i++) prog_mem[i] = '0;
    for (int i = 0; i < TAPE_DEPTH; i++) tape_mem[i] = '0;
    ip = 0;
    tp = TAPE_MID;

    // first step after reset runs the zero byte at position 0
    add_row(OP_STEP, 0, 8'h00, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 0, CH_OUT, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, PROG_DEPTH - 1, 8'hFF, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 1, CH_IN, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 2, CH_INC, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 3, CH_OUT, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 4, CH_OPEN, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 5, CH_DEC, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 6, CH_CLOSE, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 7, CH_DEC, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 8, CH_CLOSE, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 9, CH_OUT, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 10, CH_RIGHT, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, 11, CH_OPEN, 1'b1, NONE_AT_ONE);
    add_row(OP_LOAD, PROG_DEPTH - 2, CH_CLOSE, 1'b1, NONE_AT_ONE);
    add_row(OP_STEP, 0, 8'hFF, 1'b0, '0);
    add_row(OP_STEP, 0, 8'h00, 1'b0, '0);
    // cell wrapped from ff to 00
    add_row(OP_STEP, 0, 8'h00, 1'b1, {1'b1, 8'h00, 12'd4});
    add_row(OP_STEP, 0, 8'h00, 1'b0, '0);
    add_row(OP_STEP, 0, 8'h00, 1'b0, '0);
    // closing bracket with no partner falls through
    add_row(OP_STEP, PROG_DEPTH - 1, 8'hFF, 1'b0, '0);
    add_row(OP_STEP, 0, 8'h00, 1'b1, {1'b1, 8'hFF, 12'd10});
    add_row(OP_STEP, 0, 8'h00, 1'b0, '0);
    // long forward scan lands on the bracket just below the top of the store
    add_row(OP_STEP, 0, 8'h00, 1'b0, '0);
    add_row(OP_STEP, 0, 8'h00, 1'b1, {1'b0, 8'h00, 12'd0});
    add_row(OP_STEP, 0, 8'h00, 1'b1, {1'b1, 8'h00, 12'd1});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_item(stim_table[i].op, stim_table[i].addr, stim_table[i].val,
                stim_table[i].typed, stim_table[i].want);
    end
    while (sent < RANDOM_TARGET) run_segment();

    item_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads and %0d steps, %0d bytes emitted", n_loads, n_steps, n_emits);
    $display("tape pointer brought back to the middle %0d times, program end reached %0d times",
             tape_resets, store_ends);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
